>>> sv/csv_field_type_classifier_unit_assert.svh
// assertion macros for the rtl
`ifndef CSV_FIELD_TYPE_CLASSIFIER_UNIT_ASSERT_SVH
`define CSV_FIELD_TYPE_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define CFTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CFTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/cftc_pkg.sv
package cftc_pkg;

    localparam int COL_SPAN          = 64;
    localparam int FORCE_COLUMNS_DEF = 64;
    localparam int HEAD_LEN          = 10;
    localparam int CFG_DATA_W        = 64;

    localparam logic [1:0] CFG_DECIMAL_COMMA   = 2'd0;
    localparam logic [1:0] CFG_FORCE_ALL_TEXT  = 2'd1;
    localparam logic [1:0] CFG_FORCE_TEXT_MASK = 2'd2;

    localparam logic [3:0] TYPE_TEXT   = 4'd0;
    localparam logic [3:0] TYPE_NUMBER = 4'd1;
    localparam logic [3:0] TYPE_TIME   = 4'd2;
    localparam logic [3:0] TYPE_YMD    = 4'd3;
    localparam logic [3:0] TYPE_DMY    = 4'd4;
    localparam logic [3:0] TYPE_MDY    = 4'd5;
    localparam logic [3:0] TYPE_AMBIG  = 4'd6;
    localparam logic [3:0] TYPE_EMPTY  = 4'd7;
    localparam logic [3:0] TYPE_BAD    = 4'd8;

    localparam logic [7:0] CH_PERIOD = 8'd46;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_DASH   = 8'd45;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;

    localparam logic [3:0] LEN_DATE = 4'd10;
    localparam logic [3:0] LEN_TIME = 4'd8;
    localparam logic [3:0] LEN_MAX  = 4'd15;
    localparam logic [1:0] CNT_MAX  = 2'd3;

    typedef logic [HEAD_LEN-1:0][7:0] t_head;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       empty_field;
        logic [5:0] column_index;
    } t_item;

    typedef struct packed {
        t_head      head;
        logic [3:0] len;
        logic [1:0] period_cnt;
        logic [1:0] comma_cnt;
        logic [1:0] dash_cnt;
        logic [1:0] slash_cnt;
        logic [1:0] colon_cnt;
        logic       date_ok;
        logic       class_ok;
        logic       no_comma_after_point;
        logic       lead_ok;
    } t_field_stats;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [1:0] sat_inc(input logic [1:0] v);
        return (v == CNT_MAX) ? v : v + 2'd1;
    endfunction

endpackage

>>> sv/cftc_field_acc.sv
module cftc_field_acc (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  cftc_pkg::t_item       i_item,
    input  logic                  i_decimal_comma,
    output cftc_pkg::t_field_stats o_stats,
    output cftc_pkg::t_field_stats o_next
);
    import cftc_pkg::*;

    t_field_stats r_stats;
    t_field_stats n_stats;
    logic [7:0]   w_c;
    logic [7:0]   w_real_period;
    logic [7:0]   w_real_comma;
    logic         w_ends;

    assign w_c           = i_item.char_code;
    assign w_real_period = i_decimal_comma ? CH_COMMA : CH_PERIOD;
    assign w_real_comma  = i_decimal_comma ? CH_PERIOD : CH_COMMA;
    assign w_ends        = i_item.last_char || i_item.empty_field;

    always_comb begin
        n_stats = r_stats;
        if (!i_item.empty_field) begin
            if (r_stats.len < LEN_DATE) begin
                n_stats.head[r_stats.len] = w_c;
            end
            if (r_stats.len == 4'd0 && w_c != CH_DASH && w_c != w_real_period
                    && !is_digit(w_c)) begin
                n_stats.lead_ok = 1'b0;
            end
            if (!is_digit(w_c) && w_c != CH_SLASH && w_c != CH_DASH) begin
                n_stats.date_ok = 1'b0;
            end
            if (w_c == w_real_period) begin
                n_stats.period_cnt = sat_inc(r_stats.period_cnt);
            end else if (w_c == w_real_comma) begin
                if (r_stats.period_cnt != 2'd0) begin
                    n_stats.no_comma_after_point = 1'b0;
                end
                n_stats.comma_cnt = sat_inc(r_stats.comma_cnt);
            end else if (w_c == CH_DASH) begin
                n_stats.dash_cnt = sat_inc(r_stats.dash_cnt);
            end else if (w_c == CH_SLASH) begin
                n_stats.slash_cnt = sat_inc(r_stats.slash_cnt);
            end else if (w_c == CH_COLON) begin
                n_stats.colon_cnt = sat_inc(r_stats.colon_cnt);
            end else if (!is_digit(w_c)) begin
                n_stats.class_ok = 1'b0;
            end
            if (r_stats.len != LEN_MAX) begin
                n_stats.len = r_stats.len + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // head characters carry no reset
        if (i_step) begin
            r_stats.head <= n_stats.head;
        end
        if (!i_rst_n) begin
            r_stats.len                  <= '0;
            r_stats.period_cnt           <= '0;
            r_stats.comma_cnt            <= '0;
            r_stats.dash_cnt             <= '0;
            r_stats.slash_cnt            <= '0;
            r_stats.colon_cnt            <= '0;
            r_stats.date_ok              <= 1'b1;
            r_stats.class_ok             <= 1'b1;
            r_stats.no_comma_after_point <= 1'b1;
            r_stats.lead_ok              <= 1'b1;
        end else if (i_step) begin
            if (w_ends) begin
                r_stats.len                  <= '0;
                r_stats.period_cnt           <= '0;
                r_stats.comma_cnt            <= '0;
                r_stats.dash_cnt             <= '0;
                r_stats.slash_cnt            <= '0;
                r_stats.colon_cnt            <= '0;
                r_stats.date_ok              <= 1'b1;
                r_stats.class_ok             <= 1'b1;
                r_stats.no_comma_after_point <= 1'b1;
                r_stats.lead_ok              <= 1'b1;
            end else begin
                r_stats.len                  <= n_stats.len;
                r_stats.period_cnt           <= n_stats.period_cnt;
                r_stats.comma_cnt            <= n_stats.comma_cnt;
                r_stats.dash_cnt             <= n_stats.dash_cnt;
                r_stats.slash_cnt            <= n_stats.slash_cnt;
                r_stats.colon_cnt            <= n_stats.colon_cnt;
                r_stats.date_ok              <= n_stats.date_ok;
                r_stats.class_ok             <= n_stats.class_ok;
                r_stats.no_comma_after_point <= n_stats.no_comma_after_point;
                r_stats.lead_ok              <= n_stats.lead_ok;
            end
        end
    end

    assign o_stats = r_stats;
    assign o_next  = n_stats;

endmodule

>>> sv/cftc_classify.sv
module cftc_classify (
    input  cftc_pkg::t_field_stats i_stats,
    input  logic                   i_empty,
    input  logic                   i_forced,
    output logic [3:0]             o_type
);
    import cftc_pkg::*;

    // non-digit pair reads as an out-of-range value
    function automatic logic [6:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
        logic [6:0] v;
        if (is_digit(hi) && is_digit(lo)) begin
            v = 7'(hi[3:0]) * 7'd10 + 7'(lo[3:0]);
        end else begin
            v = 7'd99;
        end
        return v;
    endfunction

    logic [6:0] w_ymd_m;
    logic [6:0] w_ymd_d;
    logic [6:0] w_a;
    logic [6:0] w_b;
    logic       w_sep_ok;
    logic       w_ymd_pos;
    logic       w_dmy_pos;
    logic       w_date_hit;
    logic [3:0] w_date_type;
    logic [3:0] w_class;

    assign w_ymd_m = two_digits(i_stats.head[5], i_stats.head[6]);
    assign w_ymd_d = two_digits(i_stats.head[8], i_stats.head[9]);
    assign w_a     = two_digits(i_stats.head[0], i_stats.head[1]);
    assign w_b     = two_digits(i_stats.head[3], i_stats.head[4]);

    assign w_sep_ok = (i_stats.dash_cnt == 2'd2 && i_stats.slash_cnt == 2'd0)
                   || (i_stats.slash_cnt == 2'd2 && i_stats.dash_cnt == 2'd0);
    assign w_ymd_pos = (i_stats.head[4] == CH_SLASH && i_stats.head[7] == CH_SLASH)
                    || (i_stats.head[4] == CH_DASH && i_stats.head[7] == CH_DASH);
    assign w_dmy_pos = (i_stats.head[2] == CH_SLASH && i_stats.head[5] == CH_SLASH)
                    || (i_stats.head[2] == CH_DASH && i_stats.head[5] == CH_DASH);

    always_comb begin
        w_date_hit  = 1'b0;
        w_date_type = TYPE_AMBIG;
        if (i_stats.len == LEN_DATE && i_stats.date_ok && w_sep_ok) begin
            if (w_ymd_pos) begin
                if (w_ymd_m >= 7'd1 && w_ymd_d >= 7'd1 && w_ymd_m <= 7'd12
                        && w_ymd_d <= 7'd31) begin
                    w_date_hit  = 1'b1;
                    w_date_type = TYPE_YMD;
                end
            end else if (w_dmy_pos) begin
                if (w_a >= 7'd1 && w_b >= 7'd1 && !(w_a > 7'd12 && w_b > 7'd12)) begin
                    w_date_hit = 1'b1;
                    if (w_a > 7'd12) begin
                        w_date_type = TYPE_DMY;
                    end else if (w_b > 7'd12) begin
                        w_date_type = TYPE_MDY;
                    end else begin
                        w_date_type = TYPE_AMBIG;
                    end
                end
            end
        end
    end

    always_comb begin
        if (!i_stats.lead_ok) begin
            w_class = TYPE_TEXT;
        end else if (w_date_hit) begin
            w_class = w_date_type;
        end else if (!i_stats.class_ok) begin
            w_class = TYPE_TEXT;
        end else if (i_stats.period_cnt < 2'd2 && i_stats.dash_cnt < 2'd2
                && i_stats.no_comma_after_point && i_stats.colon_cnt == 2'd0
                && i_stats.slash_cnt == 2'd0) begin
            w_class = TYPE_NUMBER;
        end else if (i_stats.colon_cnt == 2'd2) begin
            if (i_stats.len != LEN_TIME) begin
                w_class = TYPE_TEXT;
            end else if (i_stats.head[2] == CH_COLON && i_stats.head[5] == CH_COLON) begin
                w_class = TYPE_TIME;
            end else begin
                w_class = TYPE_BAD;
            end
        end else if (i_stats.colon_cnt != 2'd0) begin
            w_class = TYPE_TEXT;
        end else begin
            w_class = TYPE_BAD;
        end
    end

    always_comb begin
        if (i_forced) begin
            o_type = TYPE_TEXT;
        end else if (i_empty) begin
            o_type = TYPE_EMPTY;
        end else begin
            o_type = w_class;
        end
    end

endmodule

>>> sv/csv_field_type_classifier_unit.sv
// channel | direction | handshake                   | payload
// in      | input     | i_in_valid / o_in_ready     | i_char_code, i_last_char,
//         |           |                             | i_empty_field, i_column_index
// out     | output    | o_out_valid / i_out_ready   | o_field_type, o_column_echo
// cfg     | input     | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// one character per cycle unless a field-ending character waits on a stalled result;
// a field's result passes the input register, classifier logic, then result register
// synchronous active-low reset clears counters, flags and config, no clearing pass
// a stalled result holds the output register; characters that do not end a field
// keep flowing, one that ends a field waits until the result register frees up
`include "csv_field_type_classifier_unit_assert.svh"

module csv_field_type_classifier_unit #(
    parameter int FORCE_COLUMNS = cftc_pkg::FORCE_COLUMNS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_char_code,
    input  logic                            i_last_char,
    input  logic                            i_empty_field,
    input  logic [5:0]                      i_column_index,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [3:0]                      o_field_type,
    output logic [5:0]                      o_column_echo,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [cftc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cftc_pkg::*;

    logic                     r_decimal_comma;
    logic                     r_force_all;
    logic [FORCE_COLUMNS-1:0] r_mask;
    logic [COL_SPAN-1:0]      w_mask_ext;

    logic         r_s1_valid;
    t_item        r_s1;
    logic         r_out_valid;
    logic [3:0]   r_out_type;
    logic [5:0]   r_out_col;

    logic         w_in_fire;
    logic         w_s1_ends;
    logic         w_out_free;
    logic         w_s1_fire;
    logic         w_forced;
    logic [3:0]   w_type;
    t_field_stats w_stats;
    t_field_stats w_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decimal_comma <= 1'b0;
            r_force_all     <= 1'b0;
            r_mask          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DECIMAL_COMMA:   r_decimal_comma <= i_cfg_data[0];
                CFG_FORCE_ALL_TEXT:  r_force_all     <= i_cfg_data[0];
                CFG_FORCE_TEXT_MASK: r_mask          <= i_cfg_data[FORCE_COLUMNS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_mask_ext                  = '0;
        w_mask_ext[FORCE_COLUMNS-1:0] = r_mask;
    end

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_s1_ends  = r_s1.last_char || r_s1.empty_field;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_fire  = r_s1_valid && (!w_s1_ends || w_out_free);
    assign o_in_ready = !r_s1_valid || w_s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1.char_code    <= i_char_code;
            r_s1.last_char    <= i_last_char;
            r_s1.empty_field  <= i_empty_field;
            r_s1.column_index <= i_column_index;
        end
    end

    cftc_field_acc u_acc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_s1_fire),
        .i_item          (r_s1),
        .i_decimal_comma (r_decimal_comma),
        .o_stats         (w_stats),
        .o_next          (w_next)
    );

    assign w_forced = r_force_all || w_mask_ext[r_s1.column_index];

    cftc_classify u_classify (
        .i_stats  (w_next),
        .i_empty  (r_s1.empty_field),
        .i_forced (w_forced),
        .o_type   (w_type)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire && w_s1_ends) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && w_s1_ends) begin
            r_out_type <= w_type;
            r_out_col  <= r_s1.column_index;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_field_type  = r_out_type;
    assign o_column_echo = r_out_col;

    `CFTC_ASSERT_NOW(a_type_range, i_clk, i_rst_n, o_out_valid, o_field_type <= TYPE_BAD)
    `CFTC_ASSERT_NOW(a_forced_text, i_clk, i_rst_n, w_s1_fire && w_s1_ends && w_forced, w_type == TYPE_TEXT)
    `CFTC_ASSERT_NEXT(a_clear_after_end, i_clk, i_rst_n, w_s1_fire && w_s1_ends, w_stats.len == 4'd0)
    `CFTC_ASSERT_NEXT(a_len_grows, i_clk, i_rst_n, w_s1_fire && !w_s1_ends, w_stats.len != 4'd0)

endmodule
